### rtl/lasd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lasd_pkg
// Shared constants and types for the longest arithmetic subsequence block.
// ----------------------------------------------------------------------------
package lasd_pkg;

  localparam int MAX_VALUE  = 511;
  localparam int MAX_LEN    = 1024;

  // fixed field widths of the channels
  localparam int VALUE_W    = 9;
  localparam int OUT_W      = 11;

  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int DIFF_COUNT = 2 * MAX_VALUE + 1;
  localparam int ROW_W      = $clog2(MAX_VALUE + 1);
  localparam int COL_W      = $clog2(DIFF_COUNT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int RAM_DEPTH  = 1 << ADDR_W;
  localparam int EPOCH_W    = 8;
  localparam int WORD_W     = EPOCH_W + LEN_W;
  // wide enough for row + MAX_VALUE and for any column
  localparam int SUM_W      = ((ROW_W + 1 > COL_W) ? ROW_W + 1 : COL_W) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [LEN_W-1:0]   count;
  } word_t;

  // one table update, aligned with the read data from the ram
  typedef struct packed {
    logic              valid;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [EPOCH_W-1:0] epoch;
    logic               best_clr;
  } ctl_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

### rtl/lasd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lasd_in_if
// Element channel: one sequence value and its start-of-sequence flag.
// ----------------------------------------------------------------------------
interface lasd_in_if;
  import lasd_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface
`default_nettype wire

### rtl/lasd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lasd_out_if
// Result channel: best subsequence length after each element.
// ----------------------------------------------------------------------------
interface lasd_out_if;
  import lasd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] best_length;

  modport source (output valid, output best_length, input ready);
  modport sink   (input valid, input best_length, output ready);
endinterface
`default_nettype wire

### rtl/lasd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lasd_ram
// Generic synchronous ram: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lasd_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### rtl/lasd_upd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lasd_upd
// Update stage: extends the predecessor run, writes back the longer count
// and tracks the best length of the current sequence.
// ----------------------------------------------------------------------------
module lasd_upd (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lasd_pkg::ctl_t              ctl,
  input  wire logic [lasd_pkg::WORD_W-1:0] rdata_cur,
  input  wire logic [lasd_pkg::WORD_W-1:0] rdata_prev,
  output lasd_pkg::wr_t                    wr,
  output logic      [lasd_pkg::LEN_W-1:0]  best
);
  import lasd_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  word_t            cur_w;
  word_t            prev_w;
  logic [LEN_W-1:0] old_cnt;
  logic [LEN_W-1:0] prev_cnt;
  logic [LEN_W-1:0] cand;
  logic [LEN_W-1:0] now_cnt;
  logic             grow;

  always_comb begin
    cur_w    = word_t'(rdata_cur);
    prev_w   = word_t'(rdata_prev);
    // entries from an older epoch count as cleared
    old_cnt  = (cur_w.epoch == ctl.epoch) ? cur_w.count : '0;
    prev_cnt = (prev_w.epoch == ctl.epoch) ? prev_w.count : '0;
    if (!ctl.op.in_range) begin
      cand = LEN_W'(1);
    end else if (prev_cnt >= LEN_MAX) begin
      cand = LEN_MAX;
    end else begin
      cand = prev_cnt + LEN_W'(1);
    end
    grow    = cand > old_cnt;
    now_cnt = grow ? cand : old_cnt;
    wr.we   = ctl.op.valid && grow;
    wr.addr = ctl.op.addr;
    wr.data = {ctl.epoch, cand};
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.best_clr) begin
      best <= '0;
    end else if (ctl.op.valid && (now_cnt > best)) begin
      best <= now_cnt;
    end
  end

`ifndef ASSERT_OFF
  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    !ctl.best_clr |=> best >= $past(best))
    else $error("best length decreased without a clear");
  a_best_cap: assert property (@(posedge clk) disable iff (rst)
    ctl.op.valid |-> best <= LEN_MAX)
    else $error("best length above saturation limit");
`endif

endmodule
`default_nettype wire

### rtl/lasd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lasd_ctrl
// Sequencer: clearing sweep, epoch, column walk with read addresses,
// and the result register.
// ----------------------------------------------------------------------------
module lasd_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  lasd_in_if.sink                          din,
  lasd_out_if.source                       dout,
  input  wire logic [lasd_pkg::LEN_W-1:0]  best,
  output lasd_pkg::ctl_t                   ctl,
  output lasd_pkg::wr_t                    clr,
  output logic      [lasd_pkg::ADDR_W-1:0] raddr_cur,
  output logic      [lasd_pkg::ADDR_W-1:0] raddr_prev
);
  import lasd_pkg::*;

  localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(DIFF_COUNT - 1);
  localparam logic [ADDR_W-1:0]  ADDR_LAST = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  state_t             state;
  state_t             state_next;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic               skip;
  logic               pending;
  logic [EPOCH_W-1:0] epoch;
  logic [ADDR_W-1:0]  clr_addr;
  op_t                op;
  logic               accept;
  logic               in_skip;
  logic               load_out;
  logic [SUM_W-1:0]   row_sum;
  logic [SUM_W-1:0]   prev_row;
  logic               in_range;

  assign in_skip = 32'(din.value) > MAX_VALUE;
  assign accept  = (state == ST_IDLE) && din.valid;

  // predecessor row = row + MAX_VALUE - col
  always_comb begin
    row_sum    = SUM_W'(row) + SUM_W'(MAX_VALUE);
    prev_row   = row_sum - SUM_W'(col);
    in_range   = (row_sum >= SUM_W'(col)) && (prev_row <= SUM_W'(MAX_VALUE));
    raddr_cur  = {row, col};
    raddr_prev = {prev_row[ROW_W-1:0], col};
  end

  always_comb begin
    state_next = state;
    din.ready  = 1'b0;
    clr.we     = 1'b0;
    clr.addr   = clr_addr;
    clr.data   = '0;
    load_out   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clr.we = 1'b1;
        if (clr_addr == ADDR_LAST) begin
          if (!pending) begin
            state_next = ST_IDLE;
          end else if (skip) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_IDLE: begin
        din.ready = 1'b1;
        if (din.valid) begin
          if (din.first && (epoch == EPOCH_MAX)) begin
            state_next = ST_CLEAR;
          end else if (in_skip) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (col == COL_LAST) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!dout.valid || dout.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      pending    <= 1'b0;
      epoch      <= '0;
      op.valid   <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (accept) begin
        pending <= 1'b1;
        // epoch wrap falls back to a full clearing sweep
        if (din.first) begin
          if (epoch == EPOCH_MAX) begin
            epoch    <= '0;
            clr_addr <= '0;
          end else begin
            epoch <= epoch + EPOCH_W'(1);
          end
        end
      end else if (load_out) begin
        pending <= 1'b0;
      end
      op.valid    <= (state == ST_RUN);
      op.in_range <= in_range;
      op.addr     <= {row, col};
      if (load_out) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row  <= ROW_W'(din.value);
      skip <= in_skip;
    end
    if (accept) begin
      col <= '0;
    end else if (state == ST_RUN) begin
      col <= col + COL_W'(1);
    end
    if (load_out) begin
      dout.best_length <= OUT_W'(best);
    end
  end

  assign ctl = '{op: op, epoch: epoch, best_clr: accept && din.first};

`ifndef ASSERT_OFF
  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !op.valid)
    else $error("table update still in flight while idle");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> col <= COL_LAST)
    else $error("column walk past last difference");
  a_run_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(op.valid) |-> $past(state) == ST_RUN)
    else $error("update issued outside column walk");
`endif

endmodule
`default_nettype wire

### rtl/longest_arith_subseq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_arith_subseq_dp
// Streaming longest arithmetic subsequence: a run table per end value and
// difference lives in one dual-read ram, updated one difference per cycle.
//
//   channel  dir  payload                 transfer when
//   din      in   value[8:0], first       din.valid && din.ready
//   dout     out  best_length[10:0]       dout.valid && dout.ready
//
// each element: an accept in ST_IDLE, a column walk over all DIFF_COUNT (1023)
// differences through the ram read-modify-write, then ST_FLUSH and ST_DONE.
// after reset a clearing sweep writes all 2**ADDR_W (524288) ram words, and
// din.ready stays low meanwhile; the sweep repeats on every 256th first flag
// when the epoch tag wraps. a new element is taken while a result still
// waits in the output register; dout stalls only hold the next result.
// ----------------------------------------------------------------------------
module longest_arith_subseq_dp (
  input  wire logic  clk,
  input  wire logic  rst,
  lasd_in_if.sink    din,
  lasd_out_if.source dout
);
  import lasd_pkg::*;

  ctl_t              ctl;
  wr_t               clr;
  wr_t               upd;
  logic [LEN_W-1:0]  best;
  logic [ADDR_W-1:0] raddr_cur;
  logic [ADDR_W-1:0] raddr_prev;
  logic [WORD_W-1:0] rdata_cur;
  logic [WORD_W-1:0] rdata_prev;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  lasd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .dout       (dout),
    .best       (best),
    .ctl        (ctl),
    .clr        (clr),
    .raddr_cur  (raddr_cur),
    .raddr_prev (raddr_prev)
  );

  lasd_upd u_upd (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rdata_cur  (rdata_cur),
    .rdata_prev (rdata_prev),
    .wr         (upd),
    .best       (best)
  );

  // sweep and updates never overlap
  assign ram_we    = clr.we || upd.we;
  assign ram_waddr = clr.we ? clr.addr : upd.addr;
  assign ram_wdata = clr.we ? clr.data : upd.data;

  lasd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_cur),
    .raddr_b (raddr_prev),
    .rdata_a (rdata_cur),
    .rdata_b (rdata_prev)
  );

`ifndef ASSERT_OFF
  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(clr.we && upd.we))
    else $error("clearing sweep collides with table update");
`endif

endmodule
`default_nettype wire

### sim/lasd_checker.sv
// ----------------------------------------------------------------------------
// lasd_checker
// Watches the element and result channels, keeps its own run-length table
// per end value and difference, and compares every best_length transfer with
// the oldest length still due.
// ----------------------------------------------------------------------------
module lasd_checker
  import lasd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lasd_in_if        din,
  lasd_out_if       dout,
  output int        fail_count,
  output int        pending,
  output int        taken
);

  localparam int CELLS = (MAX_VALUE + 1) * DIFF_COUNT;

  // a cell counts only when its tag matches the current sequence id,
  // so a clear is just a new id
  logic [OUT_W-1:0] run_len [CELLS];
  int unsigned      run_seq [CELLS];
  int unsigned      seq_id = 1;
  logic [OUT_W-1:0] best_len;
  logic [OUT_W-1:0] best_length_due [$];

  function automatic int cell_len(int idx);
    return (run_seq[idx] == seq_id) ? int'(run_len[idx]) : 0;
  endfunction

  function automatic logic [OUT_W-1:0] predict_best_length(logic [VALUE_W-1:0] value,
                                                          logic first);
    int cur;
    int prev;
    int cand;
    int now;
    int idx;
    if (first) begin
      seq_id++;
      best_len = '0;
    end
    cur = int'(value);
    // values above the table range leave it untouched
    if (cur <= MAX_VALUE) begin
      for (int col = 0; col < DIFF_COUNT; col++) begin
        prev = cur + MAX_VALUE - col;
        if (prev >= 0 && prev <= MAX_VALUE) begin
          cand = cell_len(prev * DIFF_COUNT + col) + 1;
          if (cand > MAX_LEN) cand = MAX_LEN;
        end else begin
          cand = 1;
        end
        idx = cur * DIFF_COUNT + col;
        now = cell_len(idx);
        if (cand > now) begin
          now          = cand;
          run_len[idx] = OUT_W'(now);
          run_seq[idx] = seq_id;
        end
        if (now > int'(best_len)) best_len = OUT_W'(now);
      end
    end
    return best_len;
  endfunction

  always @(posedge clk) begin : watch
    logic [OUT_W-1:0] due;
    if (rst) begin
      seq_id++;
      best_len   = '0;
      best_length_due.delete();
      fail_count = 0;
      pending    = 0;
      taken      = 0;
    end else begin
      // results leave before the element of this edge can add one
      if (dout.valid && dout.ready) begin
        if (best_length_due.size() == 0) begin
          $error("best_length: unexpected result %0d with nothing due", dout.best_length);
          fail_count++;
        end else begin
          due = best_length_due.pop_front();
          if (dout.best_length !== due) begin
            $error("best_length: expected %0d, actual %0d", due, dout.best_length);
            fail_count++;
          end
        end
      end
      if (din.valid && din.ready) begin
        best_length_due.push_back(predict_best_length(din.value, din.first));
        taken++;
      end
      pending = best_length_due.size();
    end
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives element streams into the longest arithmetic subsequence block:
// directed corner sequences, then random progressions mixed with noise,
// under three idling mixes and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
  import lasd_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;
  } element_t;

  localparam int ELEMENT_TARGET = 580;
  localparam int HOLD_CYCLES    = 5000;
  localparam int DRAIN_CYCLES   = 1100;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  element_t element_plan [$];
  int       send_idle_pct = 20;
  int       recv_idle_pct = 70;
  int       sent = 0;
  int       hold_at;
  int       fail_count;
  int       pending;
  int       taken;

  lasd_in_if  din_if ();
  lasd_out_if dout_if ();

  longest_arith_subseq_dp u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  lasd_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .din        (din_if),
    .dout       (dout_if),
    .fail_count (fail_count),
    .pending    (pending),
    .taken      (taken)
  );

  always #5 clk = ~clk;

  function automatic void add_element(int value, bit first);
    element_t e;
    e.value = VALUE_W'(value);
    e.first = first;
    element_plan.push_back(e);
  endfunction

  function automatic void plan_directed();
    // no start flag yet: continues from the state after reset,
    // widest differences with predecessors out of range
    add_element(0, 0);
    add_element(MAX_VALUE, 0);
    add_element(0, 0);
    add_element(MAX_VALUE, 0);
    // plain progression
    add_element(5, 1);
    add_element(10, 0);
    add_element(15, 0);
    add_element(20, 0);
    // falling progression across the range
    add_element(MAX_VALUE, 1);
    add_element(256, 0);
    add_element(1, 0);
    // zero difference
    add_element(7, 1);
    add_element(7, 0);
    add_element(7, 0);
    add_element(7, 0);
    // alternating bit patterns
    add_element(9'h155, 1);
    add_element(9'h0aa, 0);
    add_element(9'h155, 0);
    // single element sequence
    add_element(0, 1);
  endfunction

  function automatic void plan_random_sequence();
    int len;
    int value;
    int step;
    int kind;
    bit first_flag;
    len        = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
    first_flag = ($urandom_range(7) != 0);
    kind       = $urandom_range(9);
    value      = $urandom_range(0, MAX_VALUE);
    step       = ($urandom_range(3) == 0) ? $urandom_range(0, MAX_VALUE) : $urandom_range(0, 12);
    if ($urandom_range(1) == 1) step = -step;
    for (int n = 0; n < len; n++) begin
      if (kind >= 7 || $urandom_range(4) == 0) begin
        add_element($urandom_range(0, MAX_VALUE), first_flag && n == 0);
      end else begin
        // progression ran off the range: restart it elsewhere
        if (value < 0 || value > MAX_VALUE) value = $urandom_range(0, MAX_VALUE);
        add_element(value, first_flag && n == 0);
        value += step;
      end
    end
  endfunction

  task automatic send_element(element_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.value <= e.value;
    din_if.first <= e.first;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
  endtask

  initial begin : stimulus
    int total;
    din_if.valid <= 1'b0;
    din_if.value <= '0;
    din_if.first <= 1'b0;
    plan_directed();
    while (element_plan.size() < ELEMENT_TARGET) plan_random_sequence();
    total   = element_plan.size();
    hold_at = total - 40;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        send_idle_pct = 70;
        recv_idle_pct <= 20;
      end else if (i == 2 * total / 3) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      send_element(element_plan[i]);
      sent <= i + 1;
    end
    din_if.valid <= 1'b0;
    while (taken != total || pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_sink
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 0;
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // long stall so the block fills up and blocks its input
      if (!hold_used && sent == hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout_if.ready <= 1'b0;
      end else begin
        dout_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### longest_arith_subseq_dp.f
rtl/lasd_pkg.sv
rtl/lasd_in_if.sv
rtl/lasd_out_if.sv
rtl/lasd_ram.sv
rtl/lasd_upd.sv
rtl/lasd_ctrl.sv
rtl/longest_arith_subseq_dp.sv
sim/lasd_checker.sv
sim/tb_top.sv
